// ===== hdl/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants for the page run coalescer
// Field widths, payload structs, result kinds and config register indexes.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int unsigned VA_W    = 47;
    localparam int unsigned FRAME_W = 40;
    localparam int unsigned PA_W    = 52;
    localparam int unsigned CNT_W   = 36;
    localparam int unsigned CFG_W   = 36;

    // Capacity resets to 2^36, one bit above the written range
    localparam int unsigned CAP_W = CNT_W + 1;

    typedef enum logic [1:0] {
        KIND_RUN      = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_DONE_OVF = 2'd2
    } t_result_kind;

    typedef enum logic [0:0] {
        CFG_RUN_CAPACITY = 1'b0,
        CFG_COUNT_ONLY   = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [VA_W-1:0]    page_va;
        logic [FRAME_W-1:0] frame_number;
        logic               page_present;
        logic               last_page;
    } t_page_in;

    typedef struct packed {
        t_result_kind       result_kind;
        logic [VA_W-1:0]    run_va_start;
        logic [PA_W-1:0]    run_pa_start;
        logic [CNT_W-1:0]   run_pages;
        logic [CNT_W-1:0]   run_total;
        logic               last_result;
    } t_run_out;

endpackage

// ===== hdl/page_run_coalescer.sv =====
// ----------------------------------------------------------------------------
// page_run_coalescer: merge page records into physically contiguous runs
// Each registered page record updates the open run and pushes the run records
// it closes, plus a summary on the last record, into a four-entry result queue.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  page in   input      i_valid / o_stall  i_page  (t_page_in)
//  run out   output     o_valid / i_stall  o_run   (t_run_out)
//  config    input      i_cfg_wr_en        i_cfg_idx, i_cfg_wdata
//
// A page record is registered on accept and processed from that register once the
// queue has room for three results; its results enter the queue together.
// One record per cycle while each record yields at most one result and the output
// is not stalled; a record that yields two or three results makes the next one wait.
// The record register holds while more than one result waits in the queue.
// Synchronous active-low reset sets config to its defaults and clears run state and the queue.
// ----------------------------------------------------------------------------
module page_run_coalescer
    import prc_pkg::*;
#(
    parameter int unsigned PAGE_SHIFT = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_page_in         i_page,
    output logic             o_valid,
    input  logic             i_stall,
    output t_run_out         o_run,
    input  logic             i_cfg_wr_en,
    input  t_cfg_index       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned PA_EXT  = FRAME_W + PAGE_SHIFT;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (&v) ? v : v + 1'b1;
    endfunction

    // config
    logic [CAP_W-1:0]   r_run_capacity;
    logic               r_count_only;

    // input record register
    logic               r_in_valid;
    t_page_in           r_in;

    // run state
    logic               r_in_run;
    logic [VA_W-1:0]    r_start_va;
    logic [PA_W-1:0]    r_start_pa;
    logic [CNT_W-1:0]   r_pages;
    logic [FRAME_W-1:0] r_expected;
    logic [CNT_W-1:0]   r_runs;
    logic               r_ovf;

    // result queue
    t_run_out           r_q [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr_ptr;
    logic [Q_AW-1:0]    r_rd_ptr;
    logic [Q_AW:0]      r_q_cnt;

    logic               can_push;
    logic               push;
    logic               pop;
    logic               in_acc;

    logic               mapped;
    logic               close_a;
    logic               ok_a;
    logic               emit_a;
    logic               open_new;
    logic               upd_mapped;
    logic [CNT_W-1:0]   runs1;
    logic [CNT_W-1:0]   runs2;
    logic [PA_EXT-1:0]  pa_ext;
    logic               close_b;
    logic               ok_b;
    logic               emit_b;
    logic               last;

    logic               n_in_run;
    logic [VA_W-1:0]    n_start_va;
    logic [PA_W-1:0]    n_start_pa;
    logic [CNT_W-1:0]   n_pages;
    logic [FRAME_W-1:0] n_expected;
    logic [CNT_W-1:0]   n_runs;
    logic               n_ovf;

    t_run_out           res_a;
    t_run_out           res_b;
    t_run_out           res_s;
    logic [Q_AW-1:0]    off_b;
    logic [Q_AW-1:0]    off_s;
    logic [1:0]         push_n;

    // ---------------- handshakes ----------------
    assign can_push = (r_q_cnt <= (Q_AW+1)'(Q_DEPTH - 3));
    assign push     = r_in_valid && can_push;
    assign o_stall  = r_in_valid && !can_push;
    assign in_acc   = i_valid && !o_stall;
    assign o_valid  = (r_q_cnt != '0);
    assign pop      = o_valid && !i_stall;
    assign o_run    = r_q[r_rd_ptr];

    // ---------------- run update ----------------
    always_comb begin
        last   = r_in.last_page;
        mapped = (r_in.frame_number != '0) && r_in.page_present;

        // close the open run on an unmapped page or a frame break
        close_a = !r_ovf && r_in_run && (!mapped || (r_in.frame_number != r_expected));
        ok_a    = !(close_a && !r_count_only && ({1'b0, r_runs} >= r_run_capacity));
        emit_a  = close_a && ok_a && !r_count_only;
        runs1   = (close_a && ok_a) ? sat_inc(r_runs) : r_runs;

        upd_mapped = !r_ovf && mapped && ok_a;
        open_new   = upd_mapped && (!r_in_run || close_a);
        pa_ext     = {r_in.frame_number, PAGE_SHIFT'(0)};

        n_start_va = open_new ? r_in.page_va : r_start_va;
        n_start_pa = open_new ? pa_ext[PA_W-1:0] : r_start_pa;
        n_expected = upd_mapped ? r_in.frame_number + 1'b1 : r_expected;

        if (upd_mapped) begin
            n_pages = open_new ? CNT_W'(1) : sat_inc(r_pages);
        end else if (close_a && ok_a) begin
            n_pages = '0;
        end else begin
            n_pages = r_pages;
        end

        if (!r_ovf && ok_a) begin
            n_in_run = mapped;
        end else begin
            n_in_run = r_in_run;
        end

        // flush the run still open on the last record
        close_b = !r_ovf && ok_a && last && n_in_run;
        ok_b    = !(close_b && !r_count_only && ({1'b0, runs1} >= r_run_capacity));
        emit_b  = close_b && ok_b && !r_count_only;
        runs2   = (close_b && ok_b) ? sat_inc(runs1) : runs1;
        n_runs  = runs2;
        n_ovf   = r_ovf || (close_a && !ok_a) || (close_b && !ok_b);
        if (close_b && ok_b) begin
            n_in_run = 1'b0;
        end

        res_a.result_kind  = KIND_RUN;
        res_a.run_va_start = r_start_va;
        res_a.run_pa_start = r_start_pa;
        res_a.run_pages    = r_pages;
        res_a.run_total    = runs1;
        res_a.last_result  = !last;

        res_b.result_kind  = KIND_RUN;
        res_b.run_va_start = n_start_va;
        res_b.run_pa_start = n_start_pa;
        res_b.run_pages    = n_pages;
        res_b.run_total    = runs2;
        res_b.last_result  = 1'b0;

        res_s.result_kind  = n_ovf ? KIND_DONE_OVF : KIND_DONE;
        res_s.run_va_start = '0;
        res_s.run_pa_start = '0;
        res_s.run_pages    = '0;
        res_s.run_total    = runs2;
        res_s.last_result  = 1'b1;

        off_b  = Q_AW'(emit_a);
        off_s  = Q_AW'(emit_a) + Q_AW'(emit_b);
        push_n = 2'(emit_a) + 2'(emit_b) + 2'(last);
    end

    // ---------------- config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_capacity <= CAP_W'(1) << CNT_W;
            r_count_only   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_RUN_CAPACITY: r_run_capacity <= {1'b0, i_cfg_wdata[CNT_W-1:0]};
                CFG_COUNT_ONLY:   r_count_only   <= i_cfg_wdata[0];
                default:          r_count_only   <= r_count_only;
            endcase
        end
    end

    // ---------------- record register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (push) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_page;
        end
    end

    // ---------------- run state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run   <= 1'b0;
            r_start_va <= '0;
            r_start_pa <= '0;
            r_pages    <= '0;
            r_expected <= '0;
            r_runs     <= '0;
            r_ovf      <= 1'b0;
        end else if (push) begin
            if (last) begin
                // clear for the next array, keep config
                r_in_run   <= 1'b0;
                r_start_va <= '0;
                r_start_pa <= '0;
                r_pages    <= '0;
                r_expected <= '0;
                r_runs     <= '0;
                r_ovf      <= 1'b0;
            end else begin
                r_in_run   <= n_in_run;
                r_start_va <= n_start_va;
                r_start_pa <= n_start_pa;
                r_pages    <= n_pages;
                r_expected <= n_expected;
                r_runs     <= n_runs;
                r_ovf      <= n_ovf;
            end
        end
    end

    // ---------------- result queue ----------------
    always_ff @(posedge i_clk) begin
        if (push) begin
            if (emit_a) begin
                r_q[r_wr_ptr] <= res_a;
            end
            if (emit_b) begin
                r_q[r_wr_ptr + off_b] <= res_b;
            end
            if (last) begin
                r_q[r_wr_ptr + off_s] <= res_s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(push_n);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_q_cnt <= r_q_cnt + (push ? (Q_AW+1)'(push_n) : '0) - (Q_AW+1)'(pop);
        end
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for page_run_coalescer
// Page records go in on the valid/stall channel. A run ledger works out the
// expected run records and summaries for every accepted record. Each result
// taken from the output channel is compared field by field with the oldest
// pending one. Directed records cover run boundaries, frame wrap, capacity
// overflow and count-only mode. Random arrays follow under changing
// backpressure and register settings.
// ----------------------------------------------------------------------------
module tb
    import prc_pkg::*;
;

    localparam int unsigned PAGE_SHIFT   = 12;
    localparam int unsigned SETTLE_TICKS = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             o_stall;
    t_page_in         i_page      = '0;
    logic             o_valid;
    logic             i_stall     = 1'b0;
    t_run_out         o_run;
    logic             i_cfg_wr_en = 1'b0;
    t_cfg_index       i_cfg_idx   = CFG_RUN_CAPACITY;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               rx_hold     = 0;
    int unsigned      pages_sent  = 0;
    int unsigned      input_stalls = 0;
    int unsigned      cycle_count = 0;
    logic [VA_W-1:0]  walk_va     = '0;
    t_page_in         batch[$];

    // Tracks the open run and the run counter; queues what the block must emit
    class run_ledger;
        logic [CNT_W:0]     capacity;
        bit                 count_only;
        bit                 in_run;
        logic [VA_W-1:0]    start_va;
        logic [PA_W-1:0]    start_pa;
        logic [CNT_W-1:0]   pages;
        logic [CNT_W-1:0]   runs;
        logic [FRAME_W-1:0] next_frame;
        bit                 ovf;
        t_run_out           due_runs[$];
        int unsigned        n_pages, n_run_recs, n_done, n_done_ovf, n_errors;

        function new();
            capacity   = {1'b1, {CNT_W{1'b0}}};
            count_only = 1'b0;
            clear();
        endfunction

        function void clear();
            in_run     = 1'b0;
            start_va   = '0;
            start_pa   = '0;
            pages      = '0;
            runs       = '0;
            next_frame = '0;
            ovf        = 1'b0;
        endfunction

        function void set_reg(t_cfg_index idx, logic [CFG_W-1:0] d);
            case (idx)
                CFG_RUN_CAPACITY: capacity = {1'b0, d[CNT_W-1:0]};
                CFG_COUNT_ONLY:   count_only = d[0];
                default: ;
            endcase
        endfunction

        function void add_result(t_result_kind k, logic [VA_W-1:0] va,
                                 logic [PA_W-1:0] pa, logic [CNT_W-1:0] pg);
            t_run_out r;
            r.result_kind  = k;
            r.run_va_start = va;
            r.run_pa_start = pa;
            r.run_pages    = pg;
            r.run_total    = runs;
            r.last_result  = 1'b0;
            due_runs.push_back(r);
        endfunction

        // Returns 0 when the capacity is hit
        function bit close_run();
            if (!count_only && {1'b0, runs} >= capacity) begin
                ovf = 1'b1;
                return 1'b0;
            end
            if (runs != '1) runs++;
            if (!count_only) add_result(KIND_RUN, start_va, start_pa, pages);
            in_run = 1'b0;
            pages  = '0;
            return 1'b1;
        endfunction

        function void open_run(logic [VA_W-1:0] va, logic [FRAME_W-1:0] frame);
            start_va = va;
            start_pa = PA_W'(frame) << PAGE_SHIFT;
            pages    = '0;
            in_run   = 1'b1;
        endfunction

        function void page_accepted(t_page_in p);
            int base;
            bit ok;
            t_run_out tail;
            base = due_runs.size();
            ok   = 1'b1;
            n_pages++;
            if (!ovf) begin
                if (p.frame_number == '0 || !p.page_present) begin
                    if (in_run) ok = close_run();
                end else begin
                    if (!in_run) begin
                        open_run(p.page_va, p.frame_number);
                    end else if (p.frame_number != next_frame) begin
                        ok = close_run();
                        if (ok) open_run(p.page_va, p.frame_number);
                    end
                    if (ok) begin
                        next_frame = p.frame_number + 1'b1;
                        in_run     = 1'b1;
                        if (pages != '1) pages++;
                    end
                end
                if (ok && p.last_page && in_run) void'(close_run());
            end
            if (p.last_page) begin
                add_result(ovf ? KIND_DONE_OVF : KIND_DONE, '0, '0, '0);
                clear();
            end
            if (due_runs.size() > base) begin
                tail = due_runs.pop_back();
                tail.last_result = 1'b1;
                due_runs.push_back(tail);
            end
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                n_errors++;
            end
        endfunction

        function void run_emitted(t_run_out r);
            t_run_out e;
            if (due_runs.size() == 0) begin
                $error("result with nothing pending: kind %0d total %0d",
                       r.result_kind, r.run_total);
                n_errors++;
                return;
            end
            e = due_runs.pop_front();
            check_field("result_kind", 64'(e.result_kind), 64'(r.result_kind));
            check_field("run_va_start", 64'(e.run_va_start), 64'(r.run_va_start));
            check_field("run_pa_start", 64'(e.run_pa_start), 64'(r.run_pa_start));
            check_field("run_pages", 64'(e.run_pages), 64'(r.run_pages));
            check_field("run_total", 64'(e.run_total), 64'(r.run_total));
            check_field("last_result", 64'(e.last_result), 64'(r.last_result));
            case (e.result_kind)
                KIND_RUN:  n_run_recs++;
                KIND_DONE: n_done++;
                default:   n_done_ovf++;
            endcase
        endfunction
    endclass

    run_ledger ledger;

    page_run_coalescer #(
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_page      (i_page),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_run       (o_run),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout with %0d results pending", ledger.due_runs.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: a long hold takes priority over random stalls
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            i_stall <= 1'b1;
            rx_hold <= rx_hold - 1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) ledger.page_accepted(i_page);
            if (i_valid && o_stall) input_stalls++;
            if (o_valid && !i_stall) ledger.run_emitted(o_run);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [FRAME_W-1:0] rand_frame();
        logic [FRAME_W-1:0] f;
        f = FRAME_W'(rand64());
        return (f == '0) ? FRAME_W'(1) : f;
    endfunction

    function automatic t_page_in pg(logic [VA_W-1:0] va, logic [FRAME_W-1:0] frame,
                                    logic present, logic last);
        t_page_in p;
        p.page_va      = va;
        p.frame_number = frame;
        p.page_present = present;
        p.last_page    = last;
        return p;
    endfunction

    function automatic void queue_page(logic [FRAME_W-1:0] frame, logic present);
        batch.push_back(pg(walk_va, frame, present, $urandom_range(19) == 0));
        walk_va = walk_va + VA_W'(4096);
    endfunction

    task automatic send_page(t_page_in p);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_page  <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pages_sent++;
    endtask

    task automatic send_batch();
        foreach (batch[i]) send_page(batch[i]);
        batch.delete();
    endtask

    // Hold the sender until every pending result is out, then let the pipe settle
    task automatic drain_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.due_runs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_index idx, logic [CFG_W-1:0] d);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        ledger.set_reg(idx, d);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly ascending-frame runs; some unmapped pages, repeats and noise
    task automatic send_random_array(int segments);
        logic [FRAME_W-1:0] f;
        t_page_in tail;
        int len;
        walk_va = VA_W'(rand64());
        repeat (segments) begin
            case ($urandom_range(9))
                0: begin
                    if ($urandom_range(1)) queue_page('0, 1'($urandom_range(1)));
                    else queue_page(rand_frame(), 1'b0);
                end
                1: queue_page(rand_frame(), 1'b1);
                2: begin
                    f = rand_frame();
                    queue_page(f, 1'b1);
                    queue_page(f, 1'b1);
                end
                3: begin
                    f = '1 - FRAME_W'($urandom_range(2));
                    repeat (3) begin
                        queue_page(f, 1'b1);
                        f = f + 1'b1;
                    end
                end
                default: begin
                    f   = rand_frame();
                    len = $urandom_range(1, 6);
                    repeat (len) begin
                        queue_page(f, 1'b1);
                        f = f + 1'b1;
                    end
                end
            endcase
        end
        // Leave an array open now and then; the next one continues it
        if ($urandom_range(7) != 0) begin
            tail = batch.pop_back();
            tail.last_page = 1'b1;
            batch.push_back(tail);
        end
        send_batch();
    endtask

    task automatic random_phase(int unsigned target);
        int unsigned start;
        start = pages_sent;
        while (pages_sent - start < target) send_random_array($urandom_range(1, 5));
        drain_block();
    endtask

    initial begin
        ledger = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: capacity never reached, runs emitted
        tx_idle_pct = 14;
        rx_idle_pct = 48;
        send_page(pg(47'h0, 40'd1, 1'b1, 1'b0));
        send_page(pg(47'h1000, 40'd2, 1'b1, 1'b0));
        send_page(pg(47'h2000, 40'd3, 1'b1, 1'b0));
        send_page(pg(47'h3000, 40'd0, 1'b1, 1'b0));
        send_page(pg(47'h4000, 40'd5, 1'b0, 1'b0));
        send_page(pg('1, '1, 1'b1, 1'b0));
        // expected frame wraps to zero, so frame 1 starts a new run
        send_page(pg(47'h5000, 40'd1, 1'b1, 1'b0));
        send_page(pg(47'h6000, 40'd2, 1'b1, 1'b1));
        send_page(pg(47'h7000, 40'd7, 1'b1, 1'b1));
        send_page(pg(47'h8000, 40'd10, 1'b1, 1'b0));
        send_page(pg(47'h9000, 40'd20, 1'b1, 1'b1));
        send_page(pg(47'hA000, 40'd0, 1'b0, 1'b1));
        drain_block();

        cfg_write(CFG_RUN_CAPACITY, '0);
        send_page(pg(47'hB000, 40'd4, 1'b1, 1'b0));
        send_page(pg(47'hC000, 40'd9, 1'b1, 1'b0));
        send_page(pg(47'hD000, 40'd10, 1'b1, 1'b0));
        send_page(pg(47'hE000, 40'd11, 1'b1, 1'b1));
        drain_block();

        cfg_write(CFG_RUN_CAPACITY, CFG_W'(1));
        send_page(pg(47'hF000, 40'd4, 1'b1, 1'b0));
        send_page(pg(47'h10000, 40'd6, 1'b1, 1'b0));
        send_page(pg(47'h11000, 40'd0, 1'b1, 1'b1));
        drain_block();

        cfg_write(CFG_COUNT_ONLY, CFG_W'(1));
        send_page(pg(47'h12000, 40'd3, 1'b1, 1'b0));
        send_page(pg(47'h13000, 40'd8, 1'b1, 1'b0));
        send_page(pg(47'h14000, 40'd0, 1'b0, 1'b1));
        drain_block();

        cfg_write(CFG_COUNT_ONLY, '0);
        cfg_write(CFG_RUN_CAPACITY, '1);
        tx_idle_pct = 14;
        rx_idle_pct = 48;
        random_phase(25);

        // Small capacity: overflow is common
        cfg_write(CFG_RUN_CAPACITY, CFG_W'($urandom_range(2, 6)));
        tx_idle_pct = 48;
        rx_idle_pct = 14;
        random_phase(25);

        cfg_write(CFG_COUNT_ONLY, CFG_W'(1));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(12);

        // Hold the output while records keep coming, so the input backs up
        cfg_write(CFG_COUNT_ONLY, '0);
        cfg_write(CFG_RUN_CAPACITY, '1);
        rx_hold = 60;
        walk_va = VA_W'(rand64());
        repeat (16) queue_page(rand_frame(), 1'b1);
        queue_page('0, 1'b1);
        send_batch();
        drain_block();
        random_phase(10);

        $display("Covered %0d page records, %0d input stall cycles.",
                 ledger.n_pages, input_stalls);
        $display("Checked %0d run records, %0d summaries, %0d after overflow.",
                 ledger.n_run_recs, ledger.n_done, ledger.n_done_ovf);
        if (ledger.n_errors == 0 && ledger.due_runs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
